// ----- hdl/ole_pkg.sv -----
// shared types and constants for the ordered list engine
`timescale 1ns / 1ps
`default_nettype none
package ole_pkg;
  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned CNT_W = 5;
  localparam int unsigned POS_W = 8;

  typedef enum logic [2:0] {
    REQ_INSERT  = 3'd0,
    REQ_DELETE  = 3'd1,
    REQ_SEARCH  = 3'd2,
    REQ_SORT    = 3'd3,
    REQ_REVERSE = 3'd4,
    REQ_DUMP    = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_RANGE   = 3'd2,
    ST_MISSING = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_ROUTE,
    S_SHIFT,
    S_RD,
    S_EXEC,
    S_STAT_INIT,
    S_STAT,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INS,
    OP_DEL,
    OP_SRCH,
    OP_SORT,
    OP_REV,
    OP_DUMP
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic decide;
    logic shift_step;
    logic read_step;
    logic exec_step;
    logic stat_init;
    logic stat_step;
    logic emit;
    logic out_take;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic shift_done;
    logic exec_done;
    logic stat_done;
    logic need_shift;
    logic need_walk;
    logic emit_more;
    logic out_full;
  } sts_t;
endpackage
`default_nettype wire

// ----- hdl/ole_ctrl.sv -----
// controller state machine for the ordered list engine
`timescale 1ns / 1ps
`default_nettype none
module ole_ctrl
  import ole_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_ready,
  input  wire  out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_DECIDE;
      S_DECIDE: state_next = S_ROUTE;
      // the decoded operation is visible in the cycle after decide
      S_ROUTE: begin
        if (sts.need_shift) state_next = S_SHIFT;
        else if (sts.need_walk) state_next = S_RD;
        else state_next = S_STAT_INIT;
      end
      S_SHIFT: if (sts.shift_done) state_next = S_STAT_INIT;
      S_RD: state_next = S_EXEC;
      S_EXEC: state_next = sts.exec_done ? S_STAT_INIT : S_RD;
      S_STAT_INIT: state_next = S_STAT;
      S_STAT: if (sts.stat_done) state_next = S_EMIT;
      S_EMIT: begin
        if (!sts.out_full || out_ready)
          state_next = sts.emit_more ? S_EMIT : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    cmd.out_take = out_ready;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load_req = in_valid;
      end
      S_DECIDE: cmd.decide = 1'b1;
      S_ROUTE: ;
      S_SHIFT: cmd.shift_step = 1'b1;
      S_RD: cmd.read_step = 1'b1;
      S_EXEC: cmd.exec_step = 1'b1;
      S_STAT_INIT: cmd.stat_init = 1'b1;
      S_STAT: cmd.stat_step = 1'b1;
      S_EMIT: cmd.emit = !sts.out_full || out_ready;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- hdl/ole_dpath.sv -----
// datapath: element memory, walk counters, min/max scan and output register
`timescale 1ns / 1ps
`default_nettype none
module ole_dpath
  import ole_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned NW = $clog2(DEPTH + 1)
)(
  input  wire                         clk,
  input  wire                         rst,
  input  cmd_t                        cmd,
  output sts_t                        sts,
  input  wire  [2:0]                  req_type,
  input  wire  [POS_W-1:0]            position,
  input  wire  signed [DATA_WIDTH-1:0] value,
  output logic                        out_valid,
  output logic [2:0]                  status,
  output logic [CNT_W-1:0]            found_position,
  output logic signed [DATA_WIDTH-1:0] item_value,
  output logic [CNT_W-1:0]            element_count,
  output logic signed [DATA_WIDTH-1:0] minimum,
  output logic signed [DATA_WIDTH-1:0] maximum,
  output logic                        last
);
  localparam int unsigned PXW = ((POS_W > NW) ? POS_W : NW) + 1;

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];
  logic [NW-1:0] cnt;
  op_t op;
  logic [POS_W-1:0] pos_r;
  logic signed [DATA_WIDTH-1:0] val_r;
  logic [2:0] req_r;
  status_t st_r;
  logic [CNT_W-1:0] fpos_r;
  logic [NW-1:0] ia, ib, idx;  // walk indexes
  logic signed [DATA_WIDTH-1:0] ra, rb;
  logic signed [DATA_WIDTH-1:0] mn, mx;
  logic [NW-1:0] si;
  logic [NW-1:0] di;

  // position widened so that large positions compare against the count intact
  logic [PXW-1:0] pos_x;
  assign pos_x = PXW'(pos_r);

  // insert/delete done as one shift per cycle, read and write on one port each
  logic [NW-1:0] sh;
  logic signed [DATA_WIDTH-1:0] sh_rd;
  always_ff @(posedge clk) begin
    if (cmd.shift_step) begin
      if (op == OP_INS) begin
        if (sh > idx) mem[sh[AW-1:0]] <= mem[AW'(sh - 1'b1)];
        else mem[idx[AW-1:0]] <= val_r;
      end else if (sh + 1'b1 < cnt) begin
        mem[sh[AW-1:0]] <= mem[AW'(sh + 1'b1)];
      end
    end else if (cmd.exec_step && (op == OP_SORT || op == OP_REV)) begin
      if (op == OP_REV || ra > rb) begin
        mem[ia[AW-1:0]] <= rb;
        mem[ib[AW-1:0]] <= ra;
      end
    end
    if (cmd.read_step) begin
      ra <= mem[ia[AW-1:0]];
      rb <= mem[ib[AW-1:0]];
    end
    sh_rd <= mem[si[AW-1:0]];
  end

  // stats scan reads sh_rd one element behind si
  logic stat_v;
  logic signed [DATA_WIDTH-1:0] dump_rd;
  assign dump_rd = mem[di[AW-1:0]];

  logic exec_done_c, stat_done_c;
  always_comb begin
    exec_done_c = 1'b1;
    case (op)
      OP_SRCH: exec_done_c = (ra == val_r) || (ia + 1'b1 >= cnt);
      OP_SORT: exec_done_c = (ib + 1'b1 >= cnt) && (ia + 2'd2 >= cnt);
      OP_REV:  exec_done_c = (ia + 2'd2 >= ib);
      default: exec_done_c = 1'b1;
    endcase
  end
  assign stat_done_c = (si >= cnt) && !stat_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      out_valid <= 1'b0;
      op <= OP_NONE;
    end else begin
      if (cmd.out_take && out_valid && !cmd.emit) out_valid <= 1'b0;
      if (cmd.load_req) begin
        req_r <= req_type;
        pos_r <= position;
        val_r <= value;
        st_r <= ST_OK;
        fpos_r <= '0;
        di <= '0;
      end
      if (cmd.decide) begin
        ia <= '0;
        ib <= (req_r == REQ_SORT) ? NW'(1) : ((cnt == 0) ? '0 : cnt - 1'b1);
        case (req_r)
          REQ_INSERT: begin
            if (cnt >= NW'(DEPTH)) begin
              st_r <= ST_FULL;
              op <= OP_NONE;
            end else begin
              op <= OP_INS;
              sh <= cnt;
              idx <= (pos_x <= 1) ? '0 :
                     (pos_x > PXW'(cnt) + 1'b1) ? cnt : NW'(pos_x - 1'b1);
            end
          end
          REQ_DELETE: begin
            if (cnt == 0) begin
              st_r <= ST_EMPTY;
              op <= OP_NONE;
            end else if (pos_x > PXW'(cnt)) begin
              st_r <= ST_RANGE;
              op <= OP_NONE;
            end else begin
              op <= OP_DEL;
              sh <= (pos_x <= 1) ? '0 : NW'(pos_x - 1'b1);
            end
          end
          REQ_SEARCH: begin
            if (cnt == 0) begin
              st_r <= ST_MISSING;
              op <= OP_NONE;
            end else op <= OP_SRCH;
          end
          REQ_SORT: op <= (cnt > 1) ? OP_SORT : OP_NONE;
          REQ_REVERSE: op <= (cnt > 1) ? OP_REV : OP_NONE;
          REQ_DUMP: begin
            if (cnt == 0) begin
              st_r <= ST_EMPTY;
              op <= OP_NONE;
            end else op <= OP_DUMP;
          end
          default: op <= OP_NONE;
        endcase
      end
      if (cmd.shift_step) begin
        if (op == OP_INS) begin
          if (sh > idx) sh <= sh - 1'b1;
          else cnt <= cnt + 1'b1;
        end else begin
          if (sh + 1'b1 < cnt) sh <= sh + 1'b1;
          else cnt <= cnt - 1'b1;
        end
      end
      if (cmd.exec_step) begin
        case (op)
          OP_SRCH: begin
            if (ra == val_r) fpos_r <= CNT_W'(ia + 1'b1);
            else if (ia + 1'b1 >= cnt) st_r <= ST_MISSING;
            ia <= ia + 1'b1;
            ib <= ia + 1'b1;
          end
          OP_SORT: begin
            if (ib + 1'b1 < cnt) ib <= ib + 1'b1;
            else begin ia <= ia + 1'b1; ib <= ia + 2'd2; end
          end
          OP_REV: begin ia <= ia + 1'b1; ib <= ib - 1'b1; end
          default: ;
        endcase
      end
      if (cmd.stat_init) begin
        si <= '0;
        stat_v <= 1'b0;
        mn <= '0;
        mx <= '0;
      end
      if (cmd.stat_step) begin
        stat_v <= si < cnt;
        if (si < cnt) si <= si + 1'b1;
        if (stat_v) begin
          if (si == 1 || sh_rd < mn) mn <= sh_rd;
          if (si == 1 || sh_rd > mx) mx <= sh_rd;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        status <= st_r;
        found_position <= fpos_r;
        element_count <= CNT_W'(cnt);
        minimum <= mn;
        maximum <= mx;
        if (op == OP_DUMP) begin
          item_value <= dump_rd;
          last <= (di + 1'b1 >= cnt);
          di <= di + 1'b1;
        end else begin
          item_value <= '0;
          last <= 1'b1;
        end
      end
    end
  end

  // the shift walk finishes in the cycle that updates the count; an insert also writes its new entry then
  always_comb begin
    sts.shift_done = (op == OP_INS) ? !(sh > idx) : !(sh + 1'b1 < cnt);
    sts.exec_done = exec_done_c;
    sts.stat_done = stat_done_c;
    sts.need_shift = (op == OP_INS) || (op == OP_DEL);
    sts.need_walk = (op == OP_SRCH) || (op == OP_SORT) || (op == OP_REV);
    sts.emit_more = (op == OP_DUMP) && (di + 1'b1 < cnt);
    sts.out_full = out_valid;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= NW'(DEPTH))
    else $error("element count above depth");
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || cmd.out_take))
    else $error("result overwritten");
  a_last_one: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> element_count <= CNT_W'(DEPTH))
    else $error("bad count on last beat");
`endif
endmodule
`default_nettype wire

// ----- hdl/ordered_list_engine.sv -----
// top level of the ordered list engine
//  channel | signals                                                     | dir
//  in      | in_valid, in_ready, req_type, position, value               | in
//  out     | out_valid, out_ready, status, found_position, item_value,   | out
//          | element_count, minimum, maximum, last                       |
// one item at a time; a request is accepted, decoded and routed, insert/delete then
// shift one entry a cycle, search and reverse take a read and an execute state per
// step, sort a read and an execute state per compared pair, then the min/max scan is
// set up and run; dump one beat a cycle while the output is not stalled.
// reset empties the list; no clearing pass. a stalled result holds the engine.
`timescale 1ns / 1ps
`default_nettype none
module ordered_list_engine
  import ole_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
)(
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [2:0]                   req_type,
  input  wire  [POS_W-1:0]             position,
  input  wire  signed [DATA_WIDTH-1:0] value,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [2:0]                   status,
  output logic [CNT_W-1:0]             found_position,
  output logic signed [DATA_WIDTH-1:0] item_value,
  output logic [CNT_W-1:0]             element_count,
  output logic signed [DATA_WIDTH-1:0] minimum,
  output logic signed [DATA_WIDTH-1:0] maximum,
  output logic                         last
);
  cmd_t cmd;
  sts_t sts;

  ole_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  ole_dpath #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .req_type(req_type), .position(position), .value(value),
    .out_valid(out_valid), .status(status), .found_position(found_position),
    .item_value(item_value), .element_count(element_count),
    .minimum(minimum), .maximum(maximum), .last(last)
  );
endmodule
`default_nettype wire
